[sv/ilut_pkg.sv]
`timescale 1ns / 1ps

package ilut_pkg;

  // Field widths of the request and result channels
  localparam int MODE_W   = 1;
  localparam int ADDR_W   = 12;
  localparam int ENTRY_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 32;

  // Configuration register widths
  localparam int SCALE_W  = 24;
  localparam int OFFSET_W = 16;
  localparam int SIZE_W   = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd2;

  // Register reset values
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'h100000;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'h0000;
  localparam logic [SIZE_W-1:0]   SIZE_RESET   = 13'd4096;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_WRITE  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 1'b1;

  // Normalised position carries this many fraction bits
  localparam int POS_FRAC = 30;

  // sample - offset, exact
  localparam int DIFF_W = SAMPLE_W + 1;

  // Parameter defaults
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_FRAC_BITS   = 16;

endpackage

[sv/ilut_norm.sv]
`timescale 1ns / 1ps

module ilut_norm #(
  parameter int TABLE_DEPTH = ilut_pkg::DEF_TABLE_DEPTH,
  parameter int FRAC_BITS   = ilut_pkg::DEF_FRAC_BITS,
  parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // request side
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [ilut_pkg::MODE_W-1:0]             mode,
  input  logic [ilut_pkg::ADDR_W-1:0]             address,
  input  logic [ilut_pkg::ENTRY_W-1:0]            entry,
  input  logic [ilut_pkg::SAMPLE_W-1:0]           sample,
  // configuration
  input  logic [ilut_pkg::SCALE_W-1:0]            scale,
  input  logic [ilut_pkg::OFFSET_W-1:0]           offset,
  input  logic [ilut_pkg::SIZE_W-1:0]             table_size,
  // towards the table
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [ilut_pkg::MODE_W-1:0]             out_mode,
  output logic [ilut_pkg::ADDR_W-1:0]             out_address,
  output logic [ilut_pkg::ENTRY_W-1:0]            out_entry,
  output logic [IDX_W-1:0]                        out_idx,
  output logic [IDX_W-1:0]                        out_idx_hi,
  output logic [FRAC_BITS-1:0]                    out_frac,
  output logic                                    out_clipped
);

  localparam int DIFF_W = ilut_pkg::DIFF_W;
  localparam int P1_W   = DIFF_W + IDX_W + 1;
  localparam int POS_W  = P1_W + ilut_pkg::SCALE_W;
  localparam int PF     = ilut_pkg::POS_FRAC;

  // stage valids and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // last usable index: table_size - 1, limited to the physical depth
  logic [ilut_pkg::SIZE_W-1:0] size_m1;
  logic [IDX_W-1:0]            last0;

  always_comb begin
    size_m1 = (table_size == '0) ? '0 : table_size - ilut_pkg::SIZE_W'(1);
    if (32'(size_m1) > 32'(TABLE_DEPTH - 1)) begin
      last0 = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last0 = IDX_W'(size_m1);
    end
  end

  // stage 1: offset removal
  logic [ilut_pkg::MODE_W-1:0]  mode1;
  logic [ilut_pkg::ADDR_W-1:0]  addr1;
  logic [ilut_pkg::ENTRY_W-1:0] entry1;
  logic signed [DIFF_W-1:0]     diff1;
  logic [IDX_W-1:0]             last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mode1  <= mode;
      addr1  <= address;
      entry1 <= entry;
      diff1  <= $signed({sample[ilut_pkg::SAMPLE_W-1], sample})
              - $signed({offset[ilut_pkg::OFFSET_W-1], offset});
      last1  <= last0;
    end
  end

  // stage 2: multiply by the last index
  logic [ilut_pkg::MODE_W-1:0]  mode2;
  logic [ilut_pkg::ADDR_W-1:0]  addr2;
  logic [ilut_pkg::ENTRY_W-1:0] entry2;
  logic signed [P1_W-1:0]       p2;
  logic [IDX_W-1:0]             last2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      mode2  <= mode1;
      addr2  <= addr1;
      entry2 <= entry1;
      p2     <= diff1 * $signed({1'b0, last1});
      last2  <= last1;
    end
  end

  // stage 3: multiply by scale, position in Q.30
  logic [ilut_pkg::MODE_W-1:0]  mode3;
  logic [ilut_pkg::ADDR_W-1:0]  addr3;
  logic [ilut_pkg::ENTRY_W-1:0] entry3;
  logic signed [POS_W-1:0]      pos3;
  logic [IDX_W-1:0]             last3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      mode3  <= mode2;
      addr3  <= addr2;
      entry3 <= entry2;
      pos3   <= p2 * $signed(scale);
      last3  <= last2;
    end
  end

  // clamp the position and split it into index and fraction
  logic signed [POS_W-1:0] top;
  logic [POS_W-1:0]        cpos;
  logic                    clip;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        idx_hi;

  always_comb begin
    top = $signed(POS_W'({last3, {PF{1'b0}}}));
    if (pos3 < 0) begin
      cpos = '0;
      clip = 1'b1;
    end else if (pos3 > top) begin
      cpos = top;
      clip = 1'b1;
    end else begin
      cpos = pos3;
      clip = 1'b0;
    end
    idx    = cpos[PF +: IDX_W];
    idx_hi = (idx == last3) ? last3 : idx + IDX_W'(1);
  end

  // stage 4: table addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_mode    <= mode3;
      out_address <= addr3;
      out_entry   <= entry3;
      out_idx     <= idx;
      out_idx_hi  <= idx_hi;
      out_frac    <= cpos[PF-1 -: FRAC_BITS];
      out_clipped <= clip;
    end
  end

  assign out_valid = v4;

endmodule

[sv/ilut_mem.sv]
`timescale 1ns / 1ps

module ilut_mem #(
  parameter int TABLE_DEPTH = ilut_pkg::DEF_TABLE_DEPTH,
  parameter int FRAC_BITS   = ilut_pkg::DEF_FRAC_BITS,
  parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ilut_pkg::MODE_W-1:0]    mode,
  input  logic [ilut_pkg::ADDR_W-1:0]    address,
  input  logic [ilut_pkg::ENTRY_W-1:0]   entry,
  input  logic [IDX_W-1:0]               idx,
  input  logic [IDX_W-1:0]               idx_hi,
  input  logic [FRAC_BITS-1:0]           frac,
  input  logic                           clipped,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ilut_pkg::ENTRY_W-1:0]   out_low,
  output logic [ilut_pkg::ENTRY_W-1:0]   out_high,
  output logic [FRAC_BITS-1:0]           out_frac,
  output logic                           out_clipped
);

  logic [ilut_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];

  logic v;
  logic en;
  logic take;
  logic is_write;
  logic is_lookup;

  assign en        = !v || out_ready;
  assign in_ready  = en;
  assign take      = en && in_valid;
  assign is_write  = take && (mode == ilut_pkg::MODE_WRITE)
                   && (32'(address) < 32'(TABLE_DEPTH));
  assign is_lookup = take && (mode == ilut_pkg::MODE_LOOKUP);

  // store a write request; writes past the physical depth are dropped
  always_ff @(posedge clk) begin
    if (is_write) begin
      mem[IDX_W'(address)] <= entry;
    end
  end

  // read both neighbours of a lookup
  always_ff @(posedge clk) begin
    if (is_lookup) begin
      out_low     <= mem[idx];
      out_high    <= mem[idx_hi];
      out_frac    <= frac;
      out_clipped <= clipped;
    end
  end

  // only lookups carry on past the table
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid && (mode == ilut_pkg::MODE_LOOKUP);
    end
  end

  assign out_valid = v;

endmodule

[sv/ilut_interp.sv]
`timescale 1ns / 1ps

module ilut_interp #(
  parameter int FRAC_BITS = ilut_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ilut_pkg::ENTRY_W-1:0]   low,
  input  logic [ilut_pkg::ENTRY_W-1:0]   high,
  input  logic [FRAC_BITS-1:0]           frac,
  input  logic                           clipped,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ilut_pkg::VALUE_W-1:0]   value,
  output logic                           out_clipped
);

  localparam int D_W    = ilut_pkg::ENTRY_W + 1;
  localparam int PROD_W = D_W + FRAC_BITS + 1;

  logic v6, v7, v8;
  logic en6, en7, en8;

  assign en8      = !v8 || out_ready;
  assign en7      = !v7 || en8;
  assign en6      = !v6 || en7;
  assign in_ready = en6;

  // stage 6: slope between the neighbours
  logic signed [D_W-1:0]        d6;
  logic [ilut_pkg::ENTRY_W-1:0] low6;
  logic [FRAC_BITS-1:0]         frac6;
  logic                         clip6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      d6    <= $signed({high[ilut_pkg::ENTRY_W-1], high})
             - $signed({low[ilut_pkg::ENTRY_W-1], low});
      low6  <= low;
      frac6 <= frac;
      clip6 <= clipped;
    end
  end

  // stage 7: scale the slope by the fraction
  logic signed [PROD_W-1:0]     prod7;
  logic [ilut_pkg::ENTRY_W-1:0] low7;
  logic                         clip7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en7) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      prod7 <= d6 * $signed({1'b0, frac6});
      low7  <= low6;
      clip7 <= clip6;
    end
  end

  // stage 8: floor shift and add the base entry
  logic signed [PROD_W-1:0] step;

  assign step = prod7 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en8) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en8) begin
      value       <= low7 + step[ilut_pkg::VALUE_W-1:0];
      out_clipped <= clip7;
    end
  end

  assign out_valid = v8;

endmodule

[sv/interpolating_lut_lookup_core.sv]
`timescale 1ns / 1ps

// Interpolating lookup table. A lookup request (mode 1) maps its Q6.10 sample
// to a position (sample - offset) * scale * (table_size - 1), clamps it to the
// table, reads the two neighbouring entries and returns their linear
// interpolation in Q16.16 together with a clipped flag. A write request
// (mode 0) stores one Q16.16 entry and gives no result; fill every entry
// before a lookup can reach it. One request is taken per clock while out_ready
// does not hold the pipeline; a lookup result passes eight register stages,
// the depth being set by the two normalisation multipliers, the registered
// table read and the interpolation multiplier. Write configuration only while
// the block is idle.
module interpolating_lut_lookup_core #(
  parameter int TABLE_DEPTH = ilut_pkg::DEF_TABLE_DEPTH,
  parameter int FRAC_BITS   = ilut_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [ilut_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ilut_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ilut_pkg::MODE_W-1:0]       mode,
  input  logic [ilut_pkg::ADDR_W-1:0]       address,
  input  logic [ilut_pkg::ENTRY_W-1:0]      entry,
  input  logic [ilut_pkg::SAMPLE_W-1:0]     sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ilut_pkg::VALUE_W-1:0]      value,
  output logic                              clipped
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // configuration registers
  logic [ilut_pkg::SCALE_W-1:0]  scale;
  logic [ilut_pkg::OFFSET_W-1:0] offset;
  logic [ilut_pkg::SIZE_W-1:0]   table_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= ilut_pkg::SCALE_RESET;
      offset     <= ilut_pkg::OFFSET_RESET;
      table_size <= ilut_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ilut_pkg::CFG_SCALE:      scale      <= cfg_data[ilut_pkg::SCALE_W-1:0];
        ilut_pkg::CFG_OFFSET:     offset     <= cfg_data[ilut_pkg::OFFSET_W-1:0];
        ilut_pkg::CFG_TABLE_SIZE: table_size <= cfg_data[ilut_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // normalisation to table addresses
  logic                         n_valid;
  logic                         n_ready;
  logic [ilut_pkg::MODE_W-1:0]  n_mode;
  logic [ilut_pkg::ADDR_W-1:0]  n_address;
  logic [ilut_pkg::ENTRY_W-1:0] n_entry;
  logic [IDX_W-1:0]             n_idx;
  logic [IDX_W-1:0]             n_idx_hi;
  logic [FRAC_BITS-1:0]         n_frac;
  logic                         n_clipped;

  ilut_norm #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS),
    .IDX_W       (IDX_W)
  ) u_norm (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .address     (address),
    .entry       (entry),
    .sample      (sample),
    .scale       (scale),
    .offset      (offset),
    .table_size  (table_size),
    .out_valid   (n_valid),
    .out_ready   (n_ready),
    .out_mode    (n_mode),
    .out_address (n_address),
    .out_entry   (n_entry),
    .out_idx     (n_idx),
    .out_idx_hi  (n_idx_hi),
    .out_frac    (n_frac),
    .out_clipped (n_clipped)
  );

  // table store and neighbour read
  logic                         m_valid;
  logic                         m_ready;
  logic [ilut_pkg::ENTRY_W-1:0] m_low;
  logic [ilut_pkg::ENTRY_W-1:0] m_high;
  logic [FRAC_BITS-1:0]         m_frac;
  logic                         m_clipped;

  ilut_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (n_valid),
    .in_ready    (n_ready),
    .mode        (n_mode),
    .address     (n_address),
    .entry       (n_entry),
    .idx         (n_idx),
    .idx_hi      (n_idx_hi),
    .frac        (n_frac),
    .clipped     (n_clipped),
    .out_valid   (m_valid),
    .out_ready   (m_ready),
    .out_low     (m_low),
    .out_high    (m_high),
    .out_frac    (m_frac),
    .out_clipped (m_clipped)
  );

  // interpolation
  ilut_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (m_valid),
    .in_ready    (m_ready),
    .low         (m_low),
    .high        (m_high),
    .frac        (m_frac),
    .clipped     (m_clipped),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .out_clipped (clipped)
  );

endmodule
